// ===== rtl/fifo_queue_remove_at_index_defines.svh =====
// Assertion macros for the queue with removal at a position.
// Included by the RTL file fqr_ctrl.sv, which checks its own control logic.
`ifndef FIFO_QUEUE_REMOVE_AT_INDEX_DEFINES_SVH
`define FIFO_QUEUE_REMOVE_AT_INDEX_DEFINES_SVH

`ifndef SYNTHESIS
`define FQR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FQR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FQR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FQR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/fqr_pkg.sv =====
// Shared types and constants for the queue with removal at a position.
// Used by the cell, the control unit and the top level.
package fqr_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int VALUE_W    = 32;
    localparam int HEAD_W     = 32;
    localparam int ERR_W      = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef logic [ELEM_WIDTH-1:0] elem_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DISCARD = 1'b1
    } action_t;

    typedef struct packed {
        logic enq;
        logic del;
        idx_t index;
        cnt_t fill;
    } cell_cmd_t;

endpackage

// ===== rtl/fqr_cell.sv =====
// One storage cell of the queue chain.
// Depends on fqr_pkg for the element and command types.
module fqr_cell (
    input  logic              aclk,
    input  fqr_pkg::idx_t     cell_pos,
    input  fqr_pkg::cell_cmd_t cmd,
    input  fqr_pkg::elem_t    enq_value,
    input  fqr_pkg::elem_t    neighbor_data,
    output fqr_pkg::elem_t    data
);
    import fqr_pkg::*;

    elem_t data_reg;
    elem_t data_next;
    logic  load;
    logic  shift;

    assign load  = cmd.enq && (cmd.fill == {1'b0, cell_pos});
    assign shift = cmd.del && (cell_pos >= cmd.index);

    always_comb begin
        data_next = data_reg;
        if (load) begin
            data_next = enq_value;
        end else if (shift) begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/fqr_ctrl.sv =====
// Handshake, fill count, error decode and result register of the queue.
// Depends on fqr_pkg and on the assertion macros header.
`include "fifo_queue_remove_at_index_defines.svh"

module fqr_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fqr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fqr_pkg::M_TDATA_W-1:0]    m_tdata,
    input  fqr_pkg::elem_t                   head0,
    input  fqr_pkg::elem_t                   head1,
    output fqr_pkg::cell_cmd_t               cmd,
    output fqr_pkg::elem_t                   enq_value
);
    import fqr_pkg::*;

    cnt_t                  count_reg;
    cnt_t                  count_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  m_tdata_next;

    logic                  accept;
    action_t               action;
    idx_t                  index;
    logic                  full;
    logic                  range_bad;
    err_t                  err;
    elem_t                 head_elem;
    logic [HEAD_W-1:0]     head_out;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign action    = action_t'(s_tuser);
    assign enq_value = ELEM_WIDTH'(s_tdata[VALUE_W-1:0]);
    assign index     = s_tdata[VALUE_W +: IDX_W];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign range_bad = ({1'b0, index} >= count_reg);

    always_comb begin
        err        = ERR_NONE;
        count_next = count_reg;
        head_elem  = head0;
        unique case (action)
            ACT_ENQUEUE: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                    if (count_reg == '0) begin
                        head_elem = enq_value;
                    end
                end
            end
            ACT_DISCARD: begin
                if (range_bad) begin
                    err = ERR_RANGE;
                end else begin
                    count_next = count_reg - 1'b1;
                    if (index == '0) begin
                        head_elem = head1;
                    end
                end
            end
            default: begin
                err = ERR_NONE;
            end
        endcase
        if (!accept) begin
            count_next = count_reg;
        end
    end

    assign head_out = (count_next == '0) ? '0 : HEAD_W'(signed'(head_elem));

    assign cmd.enq   = accept && (action == ACT_ENQUEUE) && !full;
    assign cmd.del   = accept && (action == ACT_DISCARD) && !range_bad;
    assign cmd.index = index;
    assign cmd.fill  = count_reg;

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {err, (count_next == '0), count_next, head_out};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FQR_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "Fill count above depth.")
    `FQR_ASSERT_NEXT(a_enq_grows, aclk, aresetn, cmd.enq, count_reg == $past(count_reg) + 1'b1, "Enqueue did not grow the count.")
    `FQR_ASSERT_NEXT(a_err_holds, aclk, aresetn, accept && (err != ERR_NONE), count_reg == $past(count_reg), "Rejected transaction changed the count.")
    `FQR_ASSERT_IMPL(a_empty_flag, aclk, aresetn, m_tvalid_reg, m_tdata_reg[HEAD_W+CNT_W] == (m_tdata_reg[HEAD_W +: CNT_W] == '0), "Empty flag disagrees with count.")

endmodule

// ===== rtl/fifo_queue_remove_at_index.sv =====
// Latency: a result appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while m_tready is high; every cell of the
// chain loads or shifts together, and the result register accepts while it is taken.
// Reset clears the fill count and the result valid flag; the cells are not cleared.
// Queue of signed words with removal at any position, built as a chain of cells.
// Depends on fqr_pkg, fqr_cell and fqr_ctrl.
module fifo_queue_remove_at_index (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // value [31:0], index [35:32], zero [39:36]
    input  logic [fqr_pkg::S_TDATA_W-1:0] s_tdata,
    // action [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // head_value [31:0], count [36:32], is_empty [37], error [39:38]
    output logic [fqr_pkg::M_TDATA_W-1:0] m_tdata
);
    import fqr_pkg::*;

    cell_cmd_t cmd;
    elem_t     enq_value;
    elem_t     cell_data [DEPTH];
    elem_t     cell_next [DEPTH];

    fqr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .head0     (cell_data[0]),
        .head1     (cell_data[1]),
        .cmd       (cmd),
        .enq_value (enq_value)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_last
            assign cell_next[i] = '0;
        end else begin : g_mid
            assign cell_next[i] = cell_data[i+1];
        end

        fqr_cell u_cell (
            .aclk          (aclk),
            .cell_pos      (IDX_W'(i)),
            .cmd           (cmd),
            .enq_value     (enq_value),
            .neighbor_data (cell_next[i]),
            .data          (cell_data[i])
        );
    end

endmodule
